### design/assert_macros.svh
// assertion helpers, all clocked on aclk and quiet while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tlst_pkg.sv
`default_nettype none

package tlst_pkg;

    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 32;
    localparam int STAMP_W  = 63;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    localparam logic [STAMP_W-1:0] STAMP_ONES = 63'h7fff_ffff_ffff_ffff;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_BEGIN = 2'd0;
    localparam logic [FUNC_W-1:0] FN_END   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // steps of the shared arithmetic unit
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_HOLD  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CALLS = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIFF  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LOW   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_HIGH  = 3'd4;

    // one table entry
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] start;
        logic [COUNT_W-1:0] calls;
        logic [SUM_W-1:0]   sum;
        logic [STAMP_W-1:0] low0;
        logic [STAMP_W-1:0] low1;
        logic [STAMP_W-1:0] high0;
        logic [STAMP_W-1:0] high1;
    } tlst_rec_t;

    localparam tlst_rec_t REC_RESET = '{
        tag:   '0,
        start: '0,
        calls: '0,
        sum:   '0,
        low0:  STAMP_ONES,
        low1:  STAMP_ONES,
        high0: '0,
        high1: '0
    };

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                entry_valid;
        logic [TAG_W-1:0]    entry_tag;
        logic [COUNT_W-1:0]  call_count;
        logic [SUM_W-1:0]    total_time;
        logic [STAMP_W-1:0]  second_min;
        logic [STAMP_W-1:0]  second_max;
    } tlst_res_t;

endpackage

`default_nettype wire

### design/tlst_stat_alu.sv
`default_nettype none

module tlst_stat_alu import tlst_pkg::*; (
    input  logic [STEP_W-1:0]  step,
    input  tlst_rec_t          rec_in,
    input  logic [STAMP_W-1:0] now,
    input  logic [STAMP_W-1:0] dur_in,
    output tlst_rec_t          rec_out,
    output logic [STAMP_W-1:0] dur_out
);

    logic [SUM_W-1:0] op_a;
    logic [SUM_W-1:0] op_b;
    logic             op_sub;
    logic [SUM_W-1:0] add_res;

    // operand selection for the single adder
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        case (step)
            STEP_CALLS: begin
                op_a = SUM_W'(rec_in.calls);
                op_b = SUM_W'(1'b1);
            end
            STEP_DIFF: begin
                op_a   = SUM_W'(now);
                op_b   = SUM_W'(rec_in.start);
                op_sub = 1'b1;
            end
            STEP_LOW: begin
                op_a = rec_in.sum;
                op_b = SUM_W'(dur_in);
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign add_res = op_a + (op_sub ? ~op_b : op_b) + SUM_W'(op_sub);

    // per-step update of the entry
    always_comb begin
        rec_out = rec_in;
        dur_out = dur_in;
        case (step)
            STEP_CALLS: begin
                rec_out.calls = add_res[COUNT_W-1:0];
                rec_out.start = now;
            end
            STEP_DIFF: begin
                // duration wraps modulo 2^63
                dur_out = add_res[STAMP_W-1:0];
            end
            STEP_LOW: begin
                rec_out.sum = add_res;
                if (dur_in <= rec_in.low1) begin
                    if (dur_in <= rec_in.low0) begin
                        rec_out.low1 = rec_in.low0;
                        rec_out.low0 = dur_in;
                    end else begin
                        rec_out.low1 = dur_in;
                    end
                end
            end
            STEP_HIGH: begin
                if (dur_in >= rec_in.high1) begin
                    if (dur_in >= rec_in.high0) begin
                        rec_out.high1 = rec_in.high0;
                        rec_out.high0 = dur_in;
                    end else begin
                        rec_out.high1 = dur_in;
                    end
                end
            end
            default: begin
                rec_out = rec_in;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/tagged_latency_statistics_table.sv
// channel | direction | handshake        | payload
// s_      | in        | s_valid/s_ready  | s_func s_tag s_now s_entry_index
// m_      | out       | m_valid/m_ready  | m_status m_slot m_entry_valid m_entry_tag
//         |           |                  | m_call_count m_total_time m_second_min m_second_max
//
// One item at a time; s_ready is high only while the sequencer idles.
// The tag search visits one entry per cycle through the single read port of the
// entry memory; a begin hit then passes CALLS and WB, an end hit DIFF, LOW, HIGH
// and WB, a read passes READ, and a clear or a miss goes straight to OUT.
// Reset is synchronous and empties the table at once (per-entry used bits).
// A waiting result does not block the next transfer in; it only holds the
// next result until m_ready frees the output register.
`default_nettype none
`include "assert_macros.svh"

module tagged_latency_statistics_table import tlst_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [TAG_W-1:0]    s_tag,
    input  logic [STAMP_W-1:0]  s_now,
    input  logic [SLOT_W-1:0]   s_entry_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot,
    output logic                m_entry_valid,
    output logic [TAG_W-1:0]    m_entry_tag,
    output logic [COUNT_W-1:0]  m_call_count,
    output logic [SUM_W-1:0]    m_total_time,
    output logic [STAMP_W-1:0]  m_second_min,
    output logic [STAMP_W-1:0]  m_second_max
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // sequencer states
    localparam int SQ_W = 4;
    localparam logic [SQ_W-1:0] SQ_IDLE  = 4'd0;
    localparam logic [SQ_W-1:0] SQ_SCAN  = 4'd1;
    localparam logic [SQ_W-1:0] SQ_CALLS = 4'd2;
    localparam logic [SQ_W-1:0] SQ_DIFF  = 4'd3;
    localparam logic [SQ_W-1:0] SQ_LOW   = 4'd4;
    localparam logic [SQ_W-1:0] SQ_HIGH  = 4'd5;
    localparam logic [SQ_W-1:0] SQ_WB    = 4'd6;
    localparam logic [SQ_W-1:0] SQ_READ  = 4'd7;
    localparam logic [SQ_W-1:0] SQ_OUT   = 4'd8;

    logic [SQ_W-1:0]    state_reg,   state_next;
    logic [FUNC_W-1:0]  func_reg,    func_next;
    logic [TAG_W-1:0]   tag_reg,     tag_next;
    logic [STAMP_W-1:0] now_reg,     now_next;
    logic [IDX_W-1:0]   ptr_reg,     ptr_next;
    logic [STAMP_W-1:0] dur_reg,     dur_next;
    tlst_rec_t          rec_reg,     rec_next;
    logic [ENTRIES-1:0] used_reg,    used_next;
    tlst_res_t          res_reg,     res_next;
    tlst_res_t          out_reg,     out_next;
    logic               m_valid_reg, m_valid_next;

    // entry memory
    tlst_rec_t          mem [ENTRIES];
    tlst_rec_t          rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;

    logic [STEP_W-1:0]  alu_step;
    tlst_rec_t          alu_rec;
    logic [STAMP_W-1:0] alu_dur;

    logic               tag_hit;
    logic               ptr_used;
    logic               accept;
    tlst_rec_t          fresh_rec;
    tlst_rec_t          view_rec;

    assign accept   = s_valid && s_ready;
    assign tag_hit  = (rd_data_reg.tag == tag_reg);
    assign ptr_used = used_reg[ptr_reg];

    always_comb begin
        fresh_rec     = REC_RESET;
        fresh_rec.tag = tag_reg;
    end

    assign view_rec = ptr_used ? rd_data_reg : REC_RESET;

    // step of the shared unit for each state
    always_comb begin
        case (state_reg)
            SQ_CALLS: alu_step = STEP_CALLS;
            SQ_DIFF:  alu_step = STEP_DIFF;
            SQ_LOW:   alu_step = STEP_LOW;
            SQ_HIGH:  alu_step = STEP_HIGH;
            default:  alu_step = STEP_HOLD;
        endcase
    end

    tlst_stat_alu u_alu (
        .step    (alu_step),
        .rec_in  (rec_reg),
        .now     (now_reg),
        .dur_in  (dur_reg),
        .rec_out (alu_rec),
        .dur_out (alu_dur)
    );

    // read address: next entry of the search, or the entry a read asks for
    always_comb begin
        if (state_reg == SQ_SCAN) begin
            rd_addr = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        end else if (s_func == FN_READ && int'(s_entry_index) < ENTRIES) begin
            rd_addr = IDX_W'(s_entry_index);
        end else begin
            rd_addr = '0;
        end
    end

    assign wr_en = (state_reg == SQ_WB);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ptr_reg] <= rec_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        tag_next     = tag_reg;
        now_next     = now_reg;
        ptr_next     = ptr_reg;
        dur_next     = dur_reg;
        rec_next     = rec_reg;
        used_next    = used_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            SQ_IDLE: begin
                if (accept) begin
                    func_next = s_func;
                    tag_next  = s_tag;
                    now_next  = s_now;
                    ptr_next  = '0;
                    res_next  = '0;
                    case (s_func)
                        FN_CLEAR: begin
                            used_next  = '0;
                            state_next = SQ_OUT;
                        end
                        FN_READ: begin
                            if (int'(s_entry_index) < ENTRIES) begin
                                ptr_next   = IDX_W'(s_entry_index);
                                state_next = SQ_READ;
                            end else begin
                                res_next.slot = s_entry_index;
                                state_next    = SQ_OUT;
                            end
                        end
                        default: begin
                            state_next = SQ_SCAN;
                        end
                    endcase
                end
            end
            SQ_SCAN: begin
                if (func_reg == FN_BEGIN && (!ptr_used || tag_hit)) begin
                    rec_next   = ptr_used ? rd_data_reg : fresh_rec;
                    state_next = SQ_CALLS;
                end else if (func_reg == FN_END && ptr_used && tag_hit) begin
                    rec_next   = rd_data_reg;
                    state_next = SQ_DIFF;
                end else if (ptr_reg == LAST_IDX) begin
                    res_next        = '0;
                    res_next.status = (func_reg == FN_BEGIN) ? ST_FULL : ST_NOTFOUND;
                    state_next      = SQ_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            SQ_CALLS: begin
                rec_next   = alu_rec;
                state_next = SQ_WB;
            end
            SQ_DIFF: begin
                dur_next   = alu_dur;
                state_next = SQ_LOW;
            end
            SQ_LOW: begin
                rec_next   = alu_rec;
                state_next = SQ_HIGH;
            end
            SQ_HIGH: begin
                rec_next   = alu_rec;
                state_next = SQ_WB;
            end
            SQ_WB: begin
                used_next[ptr_reg]   = 1'b1;
                res_next.status      = ST_OK;
                res_next.slot        = SLOT_W'(ptr_reg);
                res_next.entry_valid = 1'b1;
                res_next.entry_tag   = rec_reg.tag;
                res_next.call_count  = rec_reg.calls;
                res_next.total_time  = rec_reg.sum;
                res_next.second_min  = rec_reg.low1;
                res_next.second_max  = rec_reg.high1;
                state_next           = SQ_OUT;
            end
            SQ_READ: begin
                res_next.status      = ST_OK;
                res_next.slot        = SLOT_W'(ptr_reg);
                res_next.entry_valid = ptr_used;
                res_next.entry_tag   = view_rec.tag;
                res_next.call_count  = view_rec.calls;
                res_next.total_time  = view_rec.sum;
                res_next.second_min  = view_rec.low1;
                res_next.second_max  = view_rec.high1;
                state_next           = SQ_OUT;
            end
            SQ_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        tag_reg  <= tag_next;
        now_reg  <= now_next;
        ptr_reg  <= ptr_next;
        dur_reg  <= dur_next;
        rec_reg  <= rec_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign s_ready       = (state_reg == SQ_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_slot        = out_reg.slot;
    assign m_entry_valid = out_reg.entry_valid;
    assign m_entry_tag   = out_reg.entry_tag;
    assign m_call_count  = out_reg.call_count;
    assign m_total_time  = out_reg.total_time;
    assign m_second_min  = out_reg.second_min;
    assign m_second_max  = out_reg.second_max;

    // checks
    `ASSERT_NEXT(a_clear_empties, accept && s_func == FN_CLEAR, used_reg == '0, "clear left used entries")
    `ASSERT_ALWAYS(a_used_prefix, ((used_reg + 1'b1) & used_reg) == '0, "used entries not contiguous from entry 0")
    `ASSERT_SAME(a_scan_in_range, state_reg == SQ_SCAN || state_reg == SQ_WB, int'(ptr_reg) < ENTRIES, "entry pointer beyond table")
    `ASSERT_SAME(a_result_source, $rose(m_valid_reg), $past(state_reg) == SQ_OUT, "result shown without completion")

endmodule

`default_nettype wire
